FILE: rtl/dfr_pkg.sv
// Shared constants, types and reciprocal table for the delta feature regression block.
`default_nettype none
package dfr_pkg;

  localparam int MaxHalfWidth = 8;
  localparam int MaxDims      = 32;
  localparam int RingSlots    = 2 * MaxHalfWidth + 1;
  localparam int RamDepth     = RingSlots * MaxDims;
  localparam int AddrW        = $clog2(RamDepth);
  localparam int SlotW        = $clog2(RingSlots);
  localparam int DimW         = $clog2(MaxDims);
  localparam int DimsW        = $clog2(MaxDims + 1);
  localparam int HalfW        = 4;
  localparam int StepW        = $clog2(2 * MaxHalfWidth);
  localparam int SampleW      = 16;
  localparam int FramesW      = 4;
  localparam int FramesSat    = 15;
  localparam int AccW         = 24;
  localparam int RecipW       = 17;
  localparam int ProdW        = AccW + RecipW;
  localparam int FracW        = 16;
  localparam int CfgDataW     = 6;
  localparam int CfgIdxW      = 1;

  localparam logic [CfgIdxW-1:0] CfgHalfWidth = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDimsInUse = 1'd1;

  localparam logic [HalfW-1:0] HalfWidthReset = 4'd2;
  localparam logic [DimsW-1:0] DimsInUseReset = 6'd13;

  typedef struct packed {
    logic take;
    logic clr_wr;
    logic pad_rd;
    logic pad_cap;
    logic wr_one;
    logic wr_fill;
    logic cnt_inc;
    logic cnt_clr;
    logic mac_rd;
    logic acc_clr;
    logic mul;
    logic emit;
    logic adv;
  } dfr_cmd_t;

  typedef struct packed {
    logic pad;
    logic first_frame;
    logic will_emit;
    logic clr_done;
    logic fill_done;
    logic mac_done;
    logic out_free;
  } dfr_status_t;

  // round(65536 / (2 * sum tau^2)) in Q0.16, half up
  function automatic logic [RecipW-1:0] recip_rom(input logic [HalfW-1:0] n);
    logic [RecipW-1:0] r;
    case (n)
      4'd1:    r = 17'd32768;
      4'd2:    r = 17'd6554;
      4'd3:    r = 17'd2341;
      4'd4:    r = 17'd1092;
      4'd5:    r = 17'd596;
      4'd6:    r = 17'd360;
      4'd7:    r = 17'd234;
      4'd8:    r = 17'd161;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/dfr_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dfr_ram #(
  parameter int Width = 16,
  parameter int Depth = 544
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/dfr_ctrl.sv
// Sequencer for clearing, history writes, multiply-accumulate and result hand-off.
`default_nettype none
module dfr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dfr_pkg::dfr_status_t status_i,
  output dfr_pkg::dfr_cmd_t        cmd_o
);
  import dfr_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PADRD  = 4'd2;
  localparam logic [3:0] S_PADCAP = 4'd3;
  localparam logic [3:0] S_WRITE  = 4'd4;
  localparam logic [3:0] S_MAC    = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_WRITE;
        end
      end
      S_PADRD: begin
        cmd_o.pad_rd = 1'b1;
        state_d      = S_PADCAP;
      end
      S_PADCAP: begin
        cmd_o.pad_cap = 1'b1;
        state_d       = S_WRITE;
      end
      S_WRITE: begin
        if (status_i.pad) begin
          state_d = S_PADRD;
        end else if (status_i.first_frame && !status_i.fill_done) begin
          cmd_o.wr_fill = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.wr_fill = status_i.first_frame;
          cmd_o.wr_one  = !status_i.first_frame;
          cmd_o.cnt_clr = 1'b1;
          cmd_o.acc_clr = 1'b1;
          state_d       = status_i.will_emit ? S_MAC : S_FINISH;
        end
      end
      S_MAC: begin
        cmd_o.mac_rd = 1'b1;
        if (status_i.mac_done) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_DRAIN;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.adv  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_FINISH: begin
        cmd_o.adv = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/dfr_datapath.sv
// History ring, counters, configuration registers, shared MAC and output register.
`default_nettype none
module dfr_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dfr_pkg::dfr_cmd_t                   cmd_i,
  output dfr_pkg::dfr_status_t                     status_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [dfr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [dfr_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire logic                                action_i,
  input  wire logic                                utterance_start_i,
  input  wire logic signed [dfr_pkg::SampleW-1:0]  sample_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [dfr_pkg::SampleW-1:0]       delta_o,
  output logic [dfr_pkg::DimW-1:0]                 dim_index_o,
  output logic                                     frame_end_o
);
  import dfr_pkg::*;

  logic [HalfW-1:0]   half_q;
  logic [DimsW-1:0]   dims_q;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [DimW-1:0]    dim_q, dim_d;
  logic [FramesW-1:0] frames_q, frames_d;
  logic [AddrW-1:0]   cnt_q;
  logic               pad_q;
  logic [SampleW-1:0] val_q;
  logic               rd_en_q;
  logic [HalfW:0]     tau_q;
  logic               neg_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [ProdW-1:0] prod_q;

  logic [HalfW-1:0]   n_eff;
  logic [DimsW-1:0]   dims_eff;
  logic               last;
  logic [StepW-1:0]   step;
  logic [SlotW-1:0]   back_k;
  logic [SlotW-1:0]   back_slot;
  logic [SlotW:0]     back_sum;
  logic [HalfW:0]     tau_d;
  logic               neg_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [SampleW-1:0] ram_wdata;
  logic [AddrW-1:0]   ram_raddr;
  logic [SampleW-1:0] ram_rdata;

  logic signed [SampleW+HalfW+1:0] term;
  logic signed [ProdW-1:0]         rnd;
  logic signed [ProdW-1:0]         quo;
  logic signed [SampleW-1:0]       sat;

  always_comb begin
    n_eff = half_q;
    if (half_q < HalfW'(1)) n_eff = HalfW'(1);
    if (half_q > HalfW'(MaxHalfWidth)) n_eff = HalfW'(MaxHalfWidth);
    dims_eff = dims_q;
    if (dims_q < DimsW'(1)) dims_eff = DimsW'(1);
    if (dims_q > DimsW'(MaxDims)) dims_eff = DimsW'(MaxDims);
  end

  assign last = ({1'b0, dim_q} + DimsW'(1)) >= dims_eff;
  assign step = cnt_q[StepW-1:0];

  // tap schedule: newer half with +tau, then older half with -tau
  always_comb begin
    if (cmd_i.pad_rd) begin
      back_k = SlotW'(1);
      tau_d  = '0;
      neg_d  = 1'b0;
    end else if ({1'b0, step} < {{(StepW+1-HalfW){1'b0}}, n_eff}) begin
      back_k = SlotW'(n_eff) - SlotW'(1) - SlotW'(step);
      tau_d  = (HalfW+1)'(step) + (HalfW+1)'(1);
      neg_d  = 1'b0;
    end else begin
      back_k = SlotW'(step) + SlotW'(1);
      tau_d  = (HalfW+1)'(step) + (HalfW+1)'(1) - (HalfW+1)'(n_eff);
      neg_d  = 1'b1;
    end
    back_sum = (SlotW+1)'(slot_q) + (SlotW+1)'(RingSlots) - (SlotW+1)'(back_k);
    if (back_sum >= (SlotW+1)'(RingSlots)) begin
      back_slot = SlotW'(back_sum - (SlotW+1)'(RingSlots));
    end else begin
      back_slot = SlotW'(back_sum);
    end
  end

  always_comb begin
    ram_we    = cmd_i.clr_wr | cmd_i.wr_one | cmd_i.wr_fill;
    ram_wdata = cmd_i.clr_wr ? '0 : val_q;
    if (cmd_i.clr_wr) begin
      ram_waddr = cnt_q;
    end else if (cmd_i.wr_fill) begin
      ram_waddr = {cnt_q[SlotW-1:0], dim_q};
    end else begin
      ram_waddr = {slot_q, dim_q};
    end
    ram_raddr = {back_slot, dim_q};
  end

  dfr_ram #(
    .Width (SampleW),
    .Depth (RamDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.pad         = pad_q;
  assign status_o.first_frame = (frames_q == '0);
  assign status_o.will_emit   = (frames_q >= n_eff);
  assign status_o.clr_done    = (cnt_q == AddrW'(RamDepth - 1));
  assign status_o.fill_done   = (cnt_q == AddrW'(RingSlots - 1));
  assign status_o.mac_done    = ({1'b0, step} == ({1'b0, n_eff} << 1) - (StepW+1)'(1));
  assign status_o.out_free    = !out_valid_o || !out_stall_i;

  always_comb begin
    slot_d   = slot_q;
    dim_d    = dim_q;
    frames_d = frames_q;
    if (cmd_i.take && utterance_start_i) begin
      dim_d    = '0;
      frames_d = '0;
    end else if (cmd_i.adv) begin
      if (last) begin
        dim_d  = '0;
        slot_d = (slot_q == SlotW'(RingSlots - 1)) ? '0 : slot_q + SlotW'(1);
        if (frames_q < FramesW'(FramesSat)) frames_d = frames_q + FramesW'(1);
      end else begin
        dim_d = dim_q + DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= HalfWidthReset;
      dims_q      <= DimsInUseReset;
      slot_q      <= '0;
      dim_q       <= '0;
      frames_q    <= '0;
      cnt_q       <= '0;
      pad_q       <= 1'b0;
      rd_en_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgHalfWidth: half_q <= cfg_data_i[HalfW-1:0];
          CfgDimsInUse: dims_q <= cfg_data_i[DimsW-1:0];
          default:      half_q <= half_q;
        endcase
      end
      slot_q   <= slot_d;
      dim_q    <= dim_d;
      frames_q <= frames_d;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + AddrW'(1);
      end
      if (cmd_i.take) begin
        pad_q <= action_i;
      end else if (cmd_i.pad_rd) begin
        pad_q <= 1'b0;
      end
      rd_en_q <= cmd_i.mac_rd;
      if (cmd_i.emit) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign term = (SampleW+HalfW+2)'($signed({1'b0, tau_q}))
              * (SampleW+HalfW+2)'($signed(ram_rdata));

  assign rnd = prod_q + ProdW'(32768);
  assign quo = rnd >>> FracW;

  always_comb begin
    if (quo > ProdW'(32767)) begin
      sat = 16'sh7fff;
    end else if (quo < -ProdW'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = quo[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      val_q <= sample_i;
    end else if (cmd_i.pad_cap) begin
      val_q <= ram_rdata;
    end
    tau_q <= tau_d;
    neg_q <= neg_d;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (rd_en_q) begin
      acc_q <= neg_q ? acc_q - AccW'(term) : acc_q + AccW'(term);
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(acc_q) * $signed(ProdW'(recip_rom(n_eff)));
    end
    if (cmd_i.emit) begin
      delta_o     <= sat;
      dim_index_o <= dim_q;
      frame_end_o <= last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/delta_feature_regression.sv
// Top level of the delta feature regression block.
// After reset a clearing pass zeroes the 544-entry frame history, with the input stalled.
// A data item with a result is written, then the shared MAC does 2N reads (N = half window), then multiply and emit.
// Pad items first read the previous frame's value for their dim from the history; items without result skip the MAC.
// The first frame of an utterance writes all 17 ring slots for each item.
// Reset is asynchronous, active low; configuration returns to half_width 2, dims 13.
`default_nettype none
module delta_feature_regression (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dfr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [dfr_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                action_i,
  input  wire logic                                utterance_start_i,
  input  wire logic signed [dfr_pkg::SampleW-1:0]  sample_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [dfr_pkg::SampleW-1:0]       delta_o,
  output logic [dfr_pkg::DimW-1:0]                 dim_index_o,
  output logic                                     frame_end_o
);
  import dfr_pkg::*;

  dfr_cmd_t    cmd;
  dfr_status_t status;

  dfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .action_i          (action_i),
    .utterance_start_i (utterance_start_i),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .delta_o           (delta_o),
    .dim_index_o       (dim_index_o),
    .frame_end_o       (frame_end_o)
  );

endmodule
`default_nettype wire

FILE: tb/sv/dfr_checker.sv
// Checker for the delta feature regression block: predicts each delta item and compares.
`timescale 1ns / 1ps
module dfr_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [dfr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [dfr_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_stall_i,
  input  wire logic                                action_i,
  input  wire logic                                utterance_start_i,
  input  wire logic signed [dfr_pkg::SampleW-1:0]  sample_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_stall_i,
  input  wire logic signed [dfr_pkg::SampleW-1:0]  delta_i,
  input  wire logic [dfr_pkg::DimW-1:0]            dim_index_i,
  input  wire logic                                frame_end_i,
  output int                                       fail_count_o,
  output int                                       pending_o
);
  import dfr_pkg::*;

  typedef struct packed {
    logic [SampleW-1:0] delta;
    logic [DimW-1:0]    dim;
    logic               frame_end;
  } delta_result_t;

  logic [SampleW-1:0] frame_ring [RingSlots][MaxDims];
  int                 ring_slot;
  int                 dim_cnt;
  int                 frame_cnt;
  logic [HalfW-1:0]   half_reg;
  logic [DimsW-1:0]   dims_reg;
  delta_result_t      delta_expected_q [$];

  function automatic int slot_ago(input int k);
    return (ring_slot + RingSlots - k) % RingSlots;
  endfunction

  task automatic predict_delta(input logic pad, input logic start,
                               input logic [SampleW-1:0] value);
    int            n;
    int            dims;
    int            d;
    int            k;
    logic          last;
    logic [15:0]   v;
    longint        acc;
    longint        den;
    longint        recip;
    longint        prod;
    longint        q;
    delta_result_t r;
    n = int'(half_reg);
    if (n < 1) n = 1;
    if (n > MaxHalfWidth) n = MaxHalfWidth;
    dims = int'(dims_reg);
    if (dims < 1) dims = 1;
    if (dims > MaxDims) dims = MaxDims;
    if (start) begin
      dim_cnt   = 0;
      frame_cnt = 0;
    end
    d    = dim_cnt % MaxDims;
    last = (dim_cnt + 1 >= dims);
    v    = pad ? frame_ring[slot_ago(1)][d] : value;
    if (frame_cnt == 0) begin
      for (k = 0; k < RingSlots; k++) frame_ring[k][d] = v;
    end else begin
      frame_ring[ring_slot][d] = v;
    end
    if (frame_cnt >= n) begin
      acc = 0;
      for (k = 1; k <= n; k++) begin
        acc += longint'(k) * (longint'($signed(frame_ring[slot_ago(n - k)][d]))
                            - longint'($signed(frame_ring[slot_ago(n + k)][d])));
      end
      den   = longint'(n * (n + 1) * (2 * n + 1) / 3);
      recip = (131072 + den) / (2 * den);
      prod  = acc * recip + 32768;
      q     = prod >>> 16;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.delta     = q[15:0];
      r.dim       = d[DimW-1:0];
      r.frame_end = last;
      delta_expected_q.push_back(r);
    end
    if (last) begin
      dim_cnt   = 0;
      ring_slot = (ring_slot + 1) % RingSlots;
      if (frame_cnt < FramesSat) frame_cnt++;
    end else begin
      dim_cnt = (dim_cnt + 1) & 31;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    delta_result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < RingSlots; s++) begin
        for (int m = 0; m < MaxDims; m++) frame_ring[s][m] = '0;
      end
      ring_slot    = 0;
      dim_cnt      = 0;
      frame_cnt    = 0;
      half_reg     = HalfWidthReset;
      dims_reg     = DimsInUseReset;
      delta_expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_delta(action_i, utterance_start_i, sample_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (delta_expected_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("dfr: unexpected item delta %0d dim %0d end %0d",
                     delta_i, dim_index_i, frame_end_i);
          end
          fail_count_o++;
        end else begin
          want = delta_expected_q.pop_front();
          if (want.delta !== delta_i || want.dim !== dim_index_i ||
              want.frame_end !== frame_end_i) begin
            if (fail_count_o < 10) begin
              $display("dfr: mismatch expected delta %0d dim %0d end %0d, got %0d %0d %0d",
                       $signed(want.delta), want.dim, want.frame_end,
                       delta_i, dim_index_i, frame_end_i);
            end
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgHalfWidth: half_reg = cfg_data_i[HalfW-1:0];
          CfgDimsInUse: dims_reg = cfg_data_i[DimsW-1:0];
          default: ;
        endcase
      end
      pending_o = delta_expected_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the delta feature regression testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import dfr_pkg::*;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index   = '0;
  logic [CfgDataW-1:0]       cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      action      = 1'b0;
  logic                      ustart      = 1'b0;
  logic signed [SampleW-1:0] sample      = '0;
  logic                      out_stall   = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic signed [SampleW-1:0] delta;
  logic [DimW-1:0]           dim_index;
  logic                      frame_end;
  int                        fail_count;
  int                        pending;
  int                        in_idle_pct  = 0;
  int                        out_idle_pct = 0;
  int                        items_sent   = 0;
  int                        cur_n        = 2;
  int                        cur_dims     = 13;

  delta_feature_regression DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (action),
    .utterance_start_i (ustart),
    .sample_i          (sample),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .delta_o           (delta),
    .dim_index_o       (dim_index),
    .frame_end_o       (frame_end)
  );

  dfr_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .action_i          (action),
    .utterance_start_i (ustart),
    .sample_i          (sample),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .delta_i           (delta),
    .dim_index_i       (dim_index),
    .frame_end_i       (frame_end),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < out_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("delta_feature_regression regression: fail");
    $finish;
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic pad, input logic start, input logic [15:0] value);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = pad;
    ustart   = start;
    sample   = value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // drain all expected items, then let the last item without a result finish
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_window(input logic [CfgDataW-1:0] half_raw,
                            input logic [CfgDataW-1:0] dims_raw);
    settle();
    write_reg(CfgHalfWidth, half_raw);
    write_reg(CfgDimsInUse, dims_raw);
    cur_n = int'(half_raw[HalfW-1:0]);
    if (cur_n < 1) cur_n = 1;
    if (cur_n > MaxHalfWidth) cur_n = MaxHalfWidth;
    cur_dims = int'(dims_raw);
    if (cur_dims < 1) cur_dims = 1;
    if (cur_dims > MaxDims) cur_dims = MaxDims;
  endtask

  task automatic send_utterance(input int frames, input int pads);
    int f;
    int d;
    for (f = 0; f < frames; f++) begin
      for (d = 0; d < cur_dims; d++) send_item(1'b0, (f == 0 && d == 0), rand_sample());
    end
    for (f = 0; f < pads; f++) begin
      for (d = 0; d < cur_dims; d++) send_item(1'b1, 1'b0, rand_sample());
    end
  endtask

  task automatic send_noise(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_item($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0, rand_sample());
    end
  endtask

  initial begin
    int sel;
    int utts;
    int u;
    int r;
    int frames;
    logic [CfgDataW-1:0] half_raw;
    logic [CfgDataW-1:0] dims_raw;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct  = 14;
    out_idle_pct = 88;
    set_window(6'd1, 6'd2);
    send_item(1'b1, 1'b1, 16'h0000);
    send_item(1'b0, 1'b0, 16'h7FFF);
    send_item(1'b0, 1'b0, 16'h8000);
    send_item(1'b0, 1'b0, 16'h7FFF);
    send_item(1'b0, 1'b0, 16'h8000);
    send_item(1'b0, 1'b0, 16'h8000);
    send_item(1'b0, 1'b0, 16'h0000);
    send_item(1'b0, 1'b0, 16'h0000);
    send_item(1'b0, 1'b0, 16'h7FFF);
    send_item(1'b0, 1'b0, 16'h7FFF);
    send_item(1'b1, 1'b0, 16'hFFFF);
    send_item(1'b1, 1'b0, 16'h0000);
    send_item(1'b1, 1'b1, 16'h5A5A);
    send_item(1'b0, 1'b0, 16'h1234);
    send_item(1'b0, 1'b0, 16'hFFFF);
    send_item(1'b0, 1'b0, 16'h0001);
    set_window(6'd2, 6'd4);
    send_item(1'b0, 1'b1, 16'h0100);
    send_item(1'b0, 1'b0, 16'hFF00);
    set_window(6'd2, 6'd1);
    send_item(1'b0, 1'b0, 16'h0005);
    send_item(1'b0, 1'b0, 16'h7FFF);
    send_item(1'b0, 1'b0, 16'h8000);
    send_item(1'b1, 1'b0, 16'h0000);

    while (items_sent < 1650) begin
      if (items_sent < 600) begin
        in_idle_pct  = 14;
        out_idle_pct = 88;
      end else if (items_sent < 1200) begin
        in_idle_pct  = 88;
        out_idle_pct = 14;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        case ($urandom_range(0, 4))
          0: begin half_raw = 6'd0;  dims_raw = 6'd0;  end
          1: begin half_raw = 6'd63; dims_raw = 6'd63; end
          2: begin half_raw = 6'd1;  dims_raw = 6'd1;  end
          3: begin half_raw = 6'd8;  dims_raw = 6'd32; end
          default: begin half_raw = 6'd9; dims_raw = 6'd33; end
        endcase
      end else if (sel <= 2) begin
        half_raw = 6'($urandom_range(0, 63));
        dims_raw = 6'($urandom_range(1, 8));
      end else begin
        half_raw = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(1, 4))
                                               : 6'($urandom_range(1, 8));
        dims_raw = 6'($urandom_range(1, 6));
      end
      set_window(half_raw, dims_raw);
      utts = $urandom_range(1, 3);
      for (u = 0; u < utts; u++) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          send_noise($urandom_range(1, 2 * cur_dims + 3));
        end else begin
          if (cur_dims > 8) frames = $urandom_range(cur_n, cur_n + 1);
          else frames = $urandom_range(1, cur_n + 4);
          send_utterance(frames, (r == 1) ? $urandom_range(0, cur_n) : cur_n);
        end
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("delta_feature_regression regression: pass");
    end else begin
      $display("delta_feature_regression regression: fail");
    end
    $finish;
  end

endmodule
